### src/bmtf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmtf_pkg
// Shared constants, types and header layout of the BMP to mono frame decoder.
// ----------------------------------------------------------------------------
package bmtf_pkg;

    localparam int WIDTH           = 400;
    localparam int HEIGHT          = 300;
    localparam int ROW_BYTES       = 50;
    localparam int PALETTE_ENTRIES = 256;

    localparam int LEN_W   = 24;
    localparam int ADDR_W  = 14;
    localparam int PAL_DEPTH = 256;

    // row strides in bytes, rows padded to 32 bits
    localparam int STRIDE1  = ((WIDTH * 1 + 31) / 32) * 4;
    localparam int STRIDE8  = ((WIDTH * 8 + 31) / 32) * 4;
    localparam int STRIDE24 = ((WIDTH * 24 + 31) / 32) * 4;
    localparam int STRIDE32 = ((WIDTH * 32 + 31) / 32) * 4;

    localparam int RBI_W = $clog2(STRIDE32 + 1);
    localparam int COL_W = $clog2(WIDTH + 1);
    localparam int ROW_W = $clog2(HEIGHT + 1);

    localparam logic [31:0] NEG_HEIGHT = 32'(-HEIGHT);

    // header byte offsets
    localparam int HDR_BYTES  = 34;
    localparam int OFF_PIX    = 10;
    localparam int OFF_DIB    = 14;
    localparam int OFF_WIDTH  = 18;
    localparam int OFF_HEIGHT = 22;
    localparam int OFF_PLANES = 26;
    localparam int OFF_BPP    = 28;
    localparam int OFF_COMP   = 30;

    localparam int MIN_LEN     = 54;
    localparam int MIN_DIB     = 40;
    localparam int BLACK_LIMIT = 384;
    localparam int GRAY_LIMIT  = 128;
    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4D;
    localparam logic [LEN_W-1:0] POS_MAX = '1;

    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        BPP_1,
        BPP_8,
        BPP_24,
        BPP_32
    } t_bpp;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SIGNATURE,
        ST_UNSUPPORTED,
        ST_BAD_SIZE,
        ST_LENGTH
    } t_status;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        fbyte;
        logic [2:0]        status;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

endpackage : bmtf_pkg
`default_nettype wire

### src/bmtf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmtf_if
// Request channels: file bytes in, frame writes and status out.
// ----------------------------------------------------------------------------
interface bmtf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface : bmtf_byte_if

interface bmtf_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [13:0] frame_address;
    logic [7:0]  frame_byte;
    logic [2:0]  status;

    modport source (output valid, result_kind, frame_address, frame_byte, status,
                    input ready);
    modport sink   (input valid, result_kind, frame_address, frame_byte, status,
                    output ready);
endinterface : bmtf_result_if
`default_nettype wire

### src/bmtf_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmtf_out_queue
// Result queue, takes up to two requests a cycle and hands out one.
// ----------------------------------------------------------------------------
module bmtf_out_queue
    import bmtf_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  t_push                  i_push0,
    input  t_push                  i_push1,
    output logic [3:0]             o_count,
    bmtf_result_if.source          o_result
);

    localparam int DEPTH = 8;

    t_result    r_mem [DEPTH];
    logic [2:0] r_wr;
    logic [2:0] r_rd;
    logic [3:0] r_count;
    logic [2:0] n_wr;
    logic [3:0] n_count;
    logic       c_pop;
    logic [2:0] c_wr1;

    assign c_pop  = o_result.valid && o_result.ready;
    assign c_wr1  = i_push0.valid ? r_wr + 3'd1 : r_wr;
    assign n_wr   = r_wr + 3'(i_push0.valid) + 3'(i_push1.valid);
    assign n_count = r_count + 4'(i_push0.valid) + 4'(i_push1.valid) - 4'(c_pop);

    always_ff @(posedge i_clk) begin
        if (i_push0.valid) begin
            r_mem[r_wr] <= i_push0.res;
        end
        if (i_push1.valid) begin
            r_mem[c_wr1] <= i_push1.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_count <= n_count;
            if (c_pop) begin
                r_rd <= r_rd + 3'd1;
            end
        end
    end

    assign o_count                = r_count;
    assign o_result.valid         = (r_count != 4'd0);
    assign o_result.result_kind   = r_mem[r_rd].kind;
    assign o_result.frame_address = r_mem[r_rd].addr;
    assign o_result.frame_byte    = r_mem[r_rd].fbyte;
    assign o_result.status        = r_mem[r_rd].status;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 4'(DEPTH))
        else $error("result queue overflow");
    a_two_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push0.valid && i_push1.valid && !c_pop) |=> r_count == $past(r_count) + 4'd2)
        else $error("double push lost an entry");
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.ready) |=> r_rd == $past(r_rd))
        else $error("read pointer moved while stalled");
`endif

endmodule : bmtf_out_queue
`default_nettype wire

### src/bmp_to_mono_frame_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_to_mono_frame_decoder
// Streams a BMP file, checks its header and writes thresholded 1-bit frame
// bytes, then a final status per file.
// ----------------------------------------------------------------------------
//  channel    dir  handshake        payload
//  i_byte     in   valid / ready    data_byte, last_byte
//  o_result   out  valid / ready    result_kind, frame_address, frame_byte, status
//  i_cfg_*    in   write enable     image_length (24 bits)
//
// One byte per cycle while i_byte is ready; an accepted byte is registered into the
// stage registers and its results are pushed to the queue from there. The palette
// flag memory, addressed by the incoming byte, is registered for the byte's stage.
// Reset is synchronous; the palette memory is not cleared.
// i_byte stalls only when the eight-entry result queue is near full.
// ----------------------------------------------------------------------------
module bmp_to_mono_frame_decoder
    import bmtf_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    bmtf_byte_if.sink         i_byte,
    bmtf_result_if.source     o_result,
    input  wire               i_cfg_we,
    input  wire [LEN_W-1:0]   i_cfg_data
);

    // ---- configuration and stage registers
    logic [LEN_W-1:0] r_len;
    logic             r_s1_valid;
    logic [7:0]       r_s1_byte;
    logic             r_s1_last;
    logic             r_s1_pal;

    // palette black flags; entry written is never read by the following byte
    logic             r_pal_mem [PAL_DEPTH];
    logic [1:0]       r_pal_bw,  n_pal_bw;

    // header fields
    logic [7:0]  r_sig0,   n_sig0;
    logic [7:0]  r_sig1,   n_sig1;
    logic [31:0] r_pix,    n_pix;
    logic [31:0] r_dib,    n_dib;
    logic [31:0] r_w,      n_w;
    logic [31:0] r_h,      n_h;
    logic [15:0] r_planes, n_planes;
    logic [15:0] r_bppw,   n_bppw;
    logic [31:0] r_comp,   n_comp;

    // decoded header and per-file state
    logic [LEN_W-1:0] r_pos,    n_pos;
    logic             r_hdr_ok, n_hdr_ok;
    t_status          r_err,    n_err;
    t_bpp             r_bpp,    n_bpp;
    logic             r_top,    n_top;
    logic [LEN_W-1:0] r_pal,    n_pal;
    logic [LEN_W-1:0] r_pixoff, n_pixoff;
    logic [LEN_W-1:0] r_gap,    n_gap;
    logic [9:0]       r_sum,    n_sum;
    logic [1:0]       r_cidx,   n_cidx;
    logic [RBI_W-1:0] r_rbi,    n_rbi;
    logic [COL_W-1:0] r_pcol,   n_pcol;
    logic [ROW_W-1:0] r_srow,   n_srow;
    logic [7:0]       r_pack,   n_pack;

    // combinational work
    logic             c_in_acc;
    logic [3:0]       c_qcount;
    t_push            c_push0, c_push1;
    logic             c_pw_en, c_pw_data;
    logic [7:0]       c_pw_addr;
    logic [LEN_W-1:0] c_p;
    logic [5:0]       c_p6;
    logic [5:0]       c_off;
    logic [31:0]      c_len32, c_stride, c_hspan, c_pal32;
    logic             c_bpp_ok;
    t_status          c_chk;
    t_bpp             c_bpp_code;
    logic [LEN_W-1:0] c_r;
    logic             c_pp_en, c_pp_black;
    logic [RBI_W-1:0] c_pp_x;
    logic [7:0]       c_pk;
    logic             c_fr_en;
    logic [7:0]       c_fr_byte;
    logic [RBI_W-1:0] c_colbyte;
    logic [ROW_W-1:0] c_dest;
    logic [31:0]      c_addr;
    logic             c_idx_bit, c_blk;
    logic             c_bad;
    t_status          c_st;
    logic [LEN_W:0]   c_cnt;

    assign c_in_acc     = i_byte.valid && i_byte.ready;
    assign i_byte.ready = (c_qcount + (r_s1_valid ? 4'd2 : 4'd0)) <= 4'd6;

    always_ff @(posedge i_clk) begin
        if (c_pw_en) begin
            r_pal_mem[c_pw_addr] <= c_pw_data;
        end
        if (c_in_acc) begin
            r_s1_pal  <= r_pal_mem[i_byte.data_byte];
            r_s1_byte <= i_byte.data_byte;
            r_s1_last <= i_byte.last_byte;
        end
    end

    always_comb begin
        n_sig0 = r_sig0;  n_sig1 = r_sig1;  n_pix = r_pix;  n_dib = r_dib;
        n_w = r_w;  n_h = r_h;  n_planes = r_planes;  n_bppw = r_bppw;
        n_comp = r_comp;
        n_pos = r_pos;  n_hdr_ok = r_hdr_ok;  n_err = r_err;  n_bpp = r_bpp;
        n_top = r_top;  n_pal = r_pal;  n_pixoff = r_pixoff;  n_gap = r_gap;
        n_sum = r_sum;  n_cidx = r_cidx;  n_rbi = r_rbi;  n_pcol = r_pcol;
        n_srow = r_srow;  n_pack = r_pack;  n_pal_bw = r_pal_bw;
        c_pw_en = 1'b0;  c_pw_addr = '0;  c_pw_data = 1'b0;
        c_pp_en = 1'b0;  c_pp_black = 1'b0;  c_pp_x = '0;  c_pk = r_pack;
        c_fr_en = 1'b0;  c_fr_byte = '1;  c_colbyte = '0;
        c_chk = ST_OK;  c_bpp_code = BPP_1;  c_bpp_ok = 1'b0;  c_stride = '0;
        c_hspan = '0;  c_pal32 = '0;  c_r = '0;  c_idx_bit = 1'b0;  c_blk = 1'b0;
        c_bad = 1'b0;  c_st = ST_OK;  c_off = '0;
        c_push0 = '0;  c_push1 = '0;

        c_p     = r_pos;
        c_p6    = c_p[5:0];
        c_len32 = 32'(r_len);
        c_cnt   = {1'b0, c_p} + 25'd1;

        if (r_s1_valid) begin
            // header capture
            if (c_p < LEN_W'(HDR_BYTES)) begin
                c_off = c_p6;
                if (c_p6 == 6'd0) n_sig0 = r_s1_byte;
                if (c_p6 == 6'd1) n_sig1 = r_s1_byte;
                if (c_p6 >= 6'(OFF_PIX) && c_p6 < 6'(OFF_DIB)) begin
                    c_off = c_p6 - 6'(OFF_PIX);
                    n_pix[8*c_off[1:0] +: 8] = r_s1_byte;
                end
                if (c_p6 >= 6'(OFF_DIB) && c_p6 < 6'(OFF_WIDTH)) begin
                    c_off = c_p6 - 6'(OFF_DIB);
                    n_dib[8*c_off[1:0] +: 8] = r_s1_byte;
                end
                if (c_p6 >= 6'(OFF_WIDTH) && c_p6 < 6'(OFF_HEIGHT)) begin
                    c_off = c_p6 - 6'(OFF_WIDTH);
                    n_w[8*c_off[1:0] +: 8] = r_s1_byte;
                end
                if (c_p6 >= 6'(OFF_HEIGHT) && c_p6 < 6'(OFF_PLANES)) begin
                    c_off = c_p6 - 6'(OFF_HEIGHT);
                    n_h[8*c_off[1:0] +: 8] = r_s1_byte;
                end
                if (c_p6 >= 6'(OFF_PLANES) && c_p6 < 6'(OFF_BPP)) begin
                    c_off = c_p6 - 6'(OFF_PLANES);
                    n_planes[8*c_off[0] +: 8] = r_s1_byte;
                end
                if (c_p6 >= 6'(OFF_BPP) && c_p6 < 6'(OFF_COMP)) begin
                    c_off = c_p6 - 6'(OFF_BPP);
                    n_bppw[8*c_off[0] +: 8] = r_s1_byte;
                end
                if (c_p6 >= 6'(OFF_COMP)) begin
                    c_off = c_p6 - 6'(OFF_COMP);
                    n_comp[8*c_off[1:0] +: 8] = r_s1_byte;
                end
            end

            if (c_p == LEN_W'(HDR_BYTES - 1)) begin
                // header check on the last header byte
                case (n_bppw)
                    16'd1:   begin c_bpp_code = BPP_1;  c_bpp_ok = 1'b1;
                                   c_stride = 32'(STRIDE1); end
                    16'd8:   begin c_bpp_code = BPP_8;  c_bpp_ok = 1'b1;
                                   c_stride = 32'(STRIDE8); end
                    16'd24:  begin c_bpp_code = BPP_24; c_bpp_ok = 1'b1;
                                   c_stride = 32'(STRIDE24); end
                    16'd32:  begin c_bpp_code = BPP_32; c_bpp_ok = 1'b1;
                                   c_stride = 32'(STRIDE32); end
                    default: begin c_bpp_code = BPP_1;  c_bpp_ok = 1'b0;
                                   c_stride = 32'(STRIDE1); end
                endcase
                c_hspan = 32'(HEIGHT) * c_stride;
                c_pal32 = n_dib + 32'd14;
                if (c_len32 < 32'(MIN_LEN) || n_sig0 != SIG_B || n_sig1 != SIG_M) begin
                    c_chk = ST_SIGNATURE;
                end else if (n_dib < 32'(MIN_DIB) || n_dib > c_len32 - 32'd14 ||
                             n_w != 32'(WIDTH) ||
                             (n_h != 32'(HEIGHT) && n_h != NEG_HEIGHT) ||
                             n_planes != 16'd1 || n_comp != 32'd0 || !c_bpp_ok) begin
                    c_chk = ST_UNSUPPORTED;
                end else if (n_pix < c_pal32 || n_pix >= c_len32 || c_stride > c_len32 ||
                             c_hspan > c_len32 - n_pix) begin
                    c_chk = ST_BAD_SIZE;
                end
                n_err    = c_chk;
                n_hdr_ok = (c_chk == ST_OK);
                n_bpp    = c_bpp_code;
                n_top    = (n_h == NEG_HEIGHT);
                n_pal    = c_pal32[LEN_W-1:0];
                n_pixoff = n_pix[LEN_W-1:0];
                n_gap    = LEN_W'(n_pix - c_pal32);
            end else if (r_hdr_ok && c_p >= LEN_W'(HDR_BYTES)) begin
                if (c_p >= r_pal && c_p < r_pixoff) begin
                    // palette entry: B, G, R, reserved
                    c_r = c_p - r_pal;
                    if (c_r[1:0] == 2'd0) begin
                        n_sum = 10'(r_s1_byte);
                    end else if (c_r[1:0] != 2'd3) begin
                        n_sum = r_sum + 10'(r_s1_byte);
                    end
                    if (c_r[1:0] == 2'd2 && c_r[LEN_W-1:2] < (LEN_W-2)'(PALETTE_ENTRIES)) begin
                        c_pw_en   = 1'b1;
                        c_pw_addr = c_r[9:2];
                        c_pw_data = (n_sum < 10'(BLACK_LIMIT));
                        if (c_r[LEN_W-1:2] == '0) n_pal_bw[0] = c_pw_data;
                        if (c_r[LEN_W-1:2] == (LEN_W-2)'(1)) n_pal_bw[1] = c_pw_data;
                    end
                    if (c_cnt[LEN_W-1:0] == r_pixoff) begin
                        n_sum = '0;
                    end
                end else if (c_p >= r_pixoff && 32'(r_srow) < 32'(HEIGHT)) begin
                    case (r_bpp)
                        BPP_1: begin
                            c_stride = 32'(STRIDE1);
                            if (32'({r_rbi, 3'b000}) < 32'(WIDTH)) begin
                                for (int k = 0; k < 8; k++) begin
                                    c_idx_bit = r_s1_byte[7-k];
                                    c_blk = 1'b0;
                                    if (32'({r_rbi, 3'b000}) + 32'(k) < 32'(WIDTH)) begin
                                        c_blk = (r_gap >= LEN_W'(8)) ? r_pal_bw[c_idx_bit]
                                                                     : !c_idx_bit;
                                    end
                                    c_fr_byte[7-k] = !c_blk;
                                end
                                c_fr_en   = 1'b1;
                                c_colbyte = r_rbi;
                            end
                        end
                        BPP_8: begin
                            c_stride = 32'(STRIDE8);
                            if (32'(r_rbi) < 32'(WIDTH)) begin
                                c_pp_en = 1'b1;
                                c_pp_x  = r_rbi;
                                if (r_gap >= LEN_W'(4) &&
                                    LEN_W'({r_s1_byte, 2'b11}) < r_gap &&
                                    {1'b0, r_s1_byte} < 9'(PALETTE_ENTRIES)) begin
                                    c_pp_black = r_s1_pal;
                                end else begin
                                    c_pp_black = (r_s1_byte < 8'(GRAY_LIMIT));
                                end
                            end
                        end
                        default: begin
                            c_stride = (r_bpp == BPP_24) ? 32'(STRIDE24) : 32'(STRIDE32);
                            if (r_cidx == 2'd0) begin
                                n_sum = 10'(r_s1_byte);
                            end else if (r_cidx != 2'd3) begin
                                n_sum = r_sum + 10'(r_s1_byte);
                            end
                            if (r_cidx == 2'd2 && 32'(r_pcol) < 32'(WIDTH)) begin
                                c_pp_en    = 1'b1;
                                c_pp_x     = RBI_W'(r_pcol);
                                c_pp_black = (n_sum < 10'(BLACK_LIMIT));
                                n_pcol     = r_pcol + 1'b1;
                            end
                            if ((r_bpp == BPP_24 && r_cidx == 2'd2) || r_cidx == 2'd3) begin
                                n_cidx = 2'd0;
                            end else begin
                                n_cidx = r_cidx + 2'd1;
                            end
                        end
                    endcase

                    if (c_pp_en) begin
                        if (c_pp_black) begin
                            c_pk = r_pack & ~(8'h80 >> c_pp_x[2:0]);
                        end
                        n_pack = c_pk;
                        if (c_pp_x[2:0] == 3'd7 || 32'(c_pp_x) == 32'(WIDTH - 1)) begin
                            c_fr_en   = 1'b1;
                            c_fr_byte = c_pk;
                            c_colbyte = c_pp_x >> 3;
                            n_pack    = 8'hFF;
                        end
                    end

                    n_rbi = r_rbi + 1'b1;
                    if (32'(r_rbi) + 32'd1 >= c_stride) begin
                        n_rbi  = '0;
                        n_pcol = '0;
                        n_cidx = '0;
                        n_sum  = '0;
                        n_pack = 8'hFF;
                        n_srow = r_srow + 1'b1;
                    end
                end
            end

            // bottom-up files land at the mirrored frame row
            c_dest = r_top ? r_srow : ROW_W'(HEIGHT - 1) - r_srow;
            c_addr = 32'(c_dest) * 32'(ROW_BYTES) + 32'(c_colbyte);
            c_push0.valid      = c_fr_en;
            c_push0.res.kind   = KIND_FRAME;
            c_push0.res.addr   = c_addr[ADDR_W-1:0];
            c_push0.res.fbyte  = c_fr_byte;
            c_push0.res.status = ST_OK;

            n_pos = (c_p != POS_MAX) ? c_p + 1'b1 : c_p;

            if (r_s1_last) begin
                if (c_p < LEN_W'(HDR_BYTES - 1)) begin
                    c_bad = (r_len < LEN_W'(MIN_LEN)) || (n_sig0 != SIG_B) ||
                            (c_p != '0 && n_sig1 != SIG_M);
                    c_st  = c_bad ? ST_SIGNATURE : ST_LENGTH;
                end else if (n_err != ST_OK) begin
                    c_st = n_err;
                end else begin
                    c_st = (c_cnt != {1'b0, r_len}) ? ST_LENGTH : ST_OK;
                end
                c_push1.valid      = 1'b1;
                c_push1.res.kind   = KIND_STATUS;
                c_push1.res.addr   = '0;
                c_push1.res.fbyte  = '0;
                c_push1.res.status = c_st;
                // next byte starts a new file
                n_pos = '0;  n_hdr_ok = 1'b0;  n_err = ST_OK;  n_sum = '0;
                n_cidx = '0;  n_rbi = '0;  n_pcol = '0;  n_srow = '0;  n_pack = 8'hFF;
            end
        end
    end

    // header fields and palette shortcut bits are payload
    always_ff @(posedge i_clk) begin
        r_sig0 <= n_sig0;  r_sig1 <= n_sig1;  r_pix <= n_pix;  r_dib <= n_dib;
        r_w <= n_w;  r_h <= n_h;  r_planes <= n_planes;  r_bppw <= n_bppw;
        r_comp <= n_comp;  r_pal_bw <= n_pal_bw;
        r_bpp <= n_bpp;  r_top <= n_top;  r_pal <= n_pal;  r_pixoff <= n_pixoff;
        r_gap <= n_gap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_s1_valid <= 1'b0;
            r_pos      <= '0;
            r_hdr_ok   <= 1'b0;
            r_err      <= ST_OK;
            r_sum      <= '0;
            r_cidx     <= '0;
            r_rbi      <= '0;
            r_pcol     <= '0;
            r_srow     <= '0;
            r_pack     <= 8'hFF;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_data;
            end
            r_s1_valid <= c_in_acc;
            r_pos      <= n_pos;
            r_hdr_ok   <= n_hdr_ok;
            r_err      <= n_err;
            r_sum      <= n_sum;
            r_cidx     <= n_cidx;
            r_rbi      <= n_rbi;
            r_pcol     <= n_pcol;
            r_srow     <= n_srow;
            r_pack     <= n_pack;
        end
    end

    bmtf_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push0  (c_push0),
        .i_push1  (c_push1),
        .o_count  (c_qcount),
        .o_result (o_result)
    );

`ifndef SYNTH
    a_stage_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_in_acc |=> r_s1_valid)
        else $error("accepted byte not processed");
    a_frame_needs_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_push0.valid |-> (r_hdr_ok && r_s1_valid))
        else $error("frame byte without valid header");
    a_file_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |=> (r_pos == '0 && !r_hdr_ok && r_err == ST_OK))
        else $error("file state not restarted");
`endif

endmodule : bmp_to_mono_frame_decoder
`default_nettype wire
